[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// No dependencies; simulation builds leave SYNTH undefined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WVF_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("wvf assertion failed");
`define WVF_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("wvf assertion failed");
`else
`define WVF_ASSERT_IMP(lbl, clk, rstn, a, c)
`define WVF_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

[rtl/wvf_pkg.sv]
// Types and constants of the waypoint velocity follower.
// No dependencies.
`default_nettype none
package wvf_pkg;
    localparam int COORD_W = 32;
    localparam int SLOT_W  = 8;
    localparam int LEN_W   = 9;
    localparam int THR_W   = 16;
    localparam int SPD_W   = 20;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 20;

    localparam logic [CFG_IW-1:0] CFG_PATH_LENGTH    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REACH_THRESHOLD = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_CRUISE_SPEED   = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd3277;
    localparam logic [SPD_W-1:0] SPD_RESET = 20'd3277;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_diff;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] waypoint_slot;
        t_coord            coord_x;
        t_coord            coord_y;
        t_coord            coord_z;
    } t_in_item;

    typedef struct packed {
        t_coord            vel_x;
        t_coord            vel_y;
        t_coord            vel_z;
        logic [SLOT_W-1:0] aimed_index;
        logic              reached;
    } t_out_item;

    typedef struct packed {
        t_coord vel_x;
        t_coord vel_y;
        t_coord vel_z;
        logic   hit;
    } t_core_res;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_LIM, ST_SQM, ST_SQA, ST_CMP, ST_SQRT,
        ST_VMUL, ST_VINIT, ST_VDIV, ST_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/wvf_ifs.sv]
// Stream and configuration channel interfaces.
// Depends on wvf_pkg.
`default_nettype none
interface wvf_in_if;
    import wvf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface wvf_out_if;
    import wvf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface wvf_cfg_if;
    import wvf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/waypoint_velocity_follower_unit.sv]
// Waypoint velocity follower, top level: config registers, target index,
// waypoint table and output register. Depends on wvf_pkg, wvf_ifs, wvf_core,
// wvf_waymem and assert_macros.svh.
//
// A waypoint write beat is taken without making the block busy. A position
// sample with a nonzero path length occupies the block from its accept to the
// next accept (no divisions when the vector to the target is zero): a square
// of the threshold, three squares and three speed products on the shared
// multiplier, a 33-step square root and three 21-step divisions on the shared
// shift-subtract unit. Ready stays low meanwhile, and longer while the
// previous result still waits in the output register; a new beat is taken
// while it waits. Samples with path length zero give no result.
`default_nettype none
`include "assert_macros.svh"
module waypoint_velocity_follower_unit #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wvf_in_if.sink     i_in,
    wvf_cfg_if.sink    i_cfg,
    wvf_out_if.source  o_out
);
    import wvf_pkg::*;

    localparam int AW   = $clog2(MAX_WAYPOINTS);
    localparam int LW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

    logic [LEN_W-1:0] r_path_len;
    logic [THR_W-1:0] r_thr;
    logic [SPD_W-1:0] r_speed;
    logic [AW-1:0]    r_target;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [LW-1:0] len_c, aim_ext, next_ext;
    logic [AW-1:0] aim_c, next_c;
    logic          acc, start, out_free, core_busy, core_done, wr_en;
    t_coord        rx, ry, rz;
    t_core_res     res;

    assign len_c = (LW'(r_path_len) > LW'(MAX_WAYPOINTS)) ? LW'(MAX_WAYPOINTS)
                                                          : LW'(r_path_len);
    assign aim_c = (LW'(r_target) >= len_c) ? '0 : r_target;
    assign aim_ext  = LW'(r_target) + LW'(1);
    assign next_c   = (aim_ext >= len_c) ? '0 : r_target + AW'(1);
    assign next_ext = LW'(next_c);

    assign acc   = i_in.valid && i_in.ready;
    assign start = acc && (i_in.data.operation == OP_SAMPLE) && (len_c != '0);
    assign wr_en = acc && (i_in.data.operation == OP_WRITE)
                   && (32'(i_in.data.waypoint_slot) < MAX_WAYPOINTS);
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = !core_busy;
    assign i_cfg.ready = 1'b1;

    wvf_waymem #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(AW'(i_in.data.waypoint_slot)),
        .i_wx   (i_in.data.coord_x),
        .i_wy   (i_in.data.coord_y),
        .i_wz   (i_in.data.coord_z),
        .i_raddr(aim_c),
        .o_rx   (rx),
        .o_ry   (ry),
        .o_rz   (rz)
    );

    wvf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_px      (i_in.data.coord_x),
        .i_py      (i_in.data.coord_y),
        .i_pz      (i_in.data.coord_z),
        .i_wx      (rx),
        .i_wy      (ry),
        .i_wz      (rz),
        .i_thr     (r_thr),
        .i_speed   (r_speed),
        .i_out_free(out_free),
        .o_busy    (core_busy),
        .o_done    (core_done),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len  <= '0;
            r_thr       <= THR_RESET;
            r_speed     <= SPD_RESET;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_PATH_LENGTH:     r_path_len <= i_cfg.data[LEN_W-1:0];
                    CFG_REACH_THRESHOLD: r_thr      <= i_cfg.data[THR_W-1:0];
                    CFG_CRUISE_SPEED:    r_speed    <= i_cfg.data[SPD_W-1:0];
                    default: ;
                endcase
            end
            // target is clamped at start, advanced on a hit at the end
            if (start) r_target <= aim_c;
            else if (core_done && res.hit) r_target <= next_c;
            if (core_done) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_out.vel_x       <= res.vel_x;
            r_out.vel_y       <= res.vel_y;
            r_out.vel_z       <= res.vel_z;
            r_out.aimed_index <= SLOT_W'(r_target);
            r_out.reached     <= res.hit;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `WVF_ASSERT_NXT(a_busy_after_sample, i_clk, i_rst_n, start, !i_in.ready)
    `WVF_ASSERT_IMP(a_target_in_path, i_clk, i_rst_n, r_out_valid, LW'(r_target) < len_c)
    `WVF_ASSERT_IMP(a_next_in_path, i_clk, i_rst_n, core_done, next_ext < len_c)
endmodule
`default_nettype wire

[rtl/wvf_waymem.sv]
// Waypoint table: one write port, one registered read port.
// Depends on wvf_pkg.
`default_nettype none
module wvf_waymem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire wvf_pkg::t_coord i_wx,
    input  wire wvf_pkg::t_coord i_wy,
    input  wire wvf_pkg::t_coord i_wz,
    input  wire logic [AW-1:0]   i_raddr,
    output wvf_pkg::t_coord      o_rx,
    output wvf_pkg::t_coord      o_ry,
    output wvf_pkg::t_coord      o_rz
);
    import wvf_pkg::*;

    t_coord r_mx [DEPTH];
    t_coord r_my [DEPTH];
    t_coord r_mz [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mx[i_waddr] <= i_wx;
            r_my[i_waddr] <= i_wy;
            r_mz[i_waddr] <= i_wz;
        end
        o_rx <= r_mx[i_raddr];
        o_ry <= r_my[i_raddr];
        o_rz <= r_mz[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/wvf_core.sv]
// Sequenced arithmetic: one shared multiplier and one shift-subtract unit
// for the square root and the three divisions. Depends on wvf_pkg.
`default_nettype none
module wvf_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire wvf_pkg::t_coord           i_px,
    input  wire wvf_pkg::t_coord           i_py,
    input  wire wvf_pkg::t_coord           i_pz,
    input  wire wvf_pkg::t_coord           i_wx,
    input  wire wvf_pkg::t_coord           i_wy,
    input  wire wvf_pkg::t_coord           i_wz,
    input  wire logic [wvf_pkg::THR_W-1:0] i_thr,
    input  wire logic [wvf_pkg::SPD_W-1:0] i_speed,
    input  wire logic                      i_out_free,
    output logic                           o_busy,
    output logic                           o_done,
    output wvf_pkg::t_core_res             o_res
);
    import wvf_pkg::*;

    localparam int MW  = COORD_W + 1;      // magnitude width
    localparam int PW  = 2 * MW;           // product / sum of squares
    localparam int RTW = MW;               // root width
    localparam int RW  = RTW + 2;          // partial remainder
    localparam int UW  = RW + 2;           // unit operand width
    localparam int QW  = SPD_W + 1;        // quotient steps
    localparam int CW  = $clog2(RTW + 1);

    t_state r_st, n_st;
    t_coord r_px, r_py, r_pz;
    t_diff  r_d [3];
    logic [1:0]    r_ax;
    logic [PW-1:0] r_prod, r_s, r_num;
    logic [PW-1:0] r_lim;
    logic [RW-1:0] r_rem;
    logic [RTW-1:0] r_root;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_hit;
    t_coord        r_vel [3];

    logic [MW-1:0] mul_a, mul_b, d_mag;
    logic [PW-1:0] mul_p;
    logic [UW-1:0] u_sh, u_trial;
    logic [UW:0]   u_diff;
    logic          u_ge;
    t_diff         d_cur;
    logic [COORD_W-1:0] q_ext;

    assign d_cur = r_d[r_ax];
    assign d_mag = d_cur[COORD_W] ? MW'(-d_cur) : MW'(d_cur);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_start) n_st = ST_LOAD;
            ST_LOAD:  n_st = ST_LIM;
            ST_LIM:   n_st = ST_SQM;
            ST_SQM:   n_st = ST_SQA;
            ST_SQA:   n_st = (r_ax == 2'd2) ? ST_CMP : ST_SQM;
            ST_CMP:   n_st = ST_SQRT;
            ST_SQRT:  if (r_cnt == CW'(RTW - 1)) n_st = ST_VMUL;
            ST_VMUL:  n_st = ST_VINIT;
            ST_VINIT: begin
                if (r_root == '0) n_st = (r_ax == 2'd2) ? ST_DONE : ST_VMUL;
                else n_st = ST_VDIV;
            end
            ST_VDIV:  begin
                if (r_cnt == CW'(QW - 1)) n_st = (r_ax == 2'd2) ? ST_DONE : ST_VMUL;
            end
            ST_DONE:  if (i_out_free) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // operand selection for the shared units
    always_comb begin
        mul_a   = d_mag;
        mul_b   = d_mag;
        u_sh    = {1'b0, r_rem, r_num[PW-1]};
        u_trial = UW'(r_root);
        case (r_st)
            ST_LOAD: begin
                mul_a = MW'(i_thr);
                mul_b = MW'(i_thr);
            end
            ST_VMUL: mul_b = MW'(i_speed);
            ST_SQRT: begin
                u_sh    = {r_rem, r_num[PW-1 -: 2]};
                u_trial = UW'({r_root, 2'b01});
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign u_diff = {1'b0, u_sh} - {1'b0, u_trial};
    assign u_ge   = !u_diff[UW];
    assign q_ext  = COORD_W'({r_q[QW-2:0], u_ge});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_px <= i_px;
                r_py <= i_py;
                r_pz <= i_pz;
            end
            ST_LOAD: begin
                r_d[0] <= {i_wx[COORD_W-1], i_wx} - {r_px[COORD_W-1], r_px};
                r_d[1] <= {i_wy[COORD_W-1], i_wy} - {r_py[COORD_W-1], r_py};
                r_d[2] <= {i_wz[COORD_W-1], i_wz} - {r_pz[COORD_W-1], r_pz};
                r_prod <= mul_p;
                r_s    <= '0;
            end
            ST_LIM: begin
                r_lim <= r_prod + {r_prod[PW-2:0], 1'b0};
                r_ax  <= 2'd0;
            end
            ST_SQM: r_prod <= mul_p;
            ST_SQA: begin
                r_s  <= r_s + r_prod;
                r_ax <= r_ax + 2'd1;
            end
            ST_CMP: begin
                r_hit  <= (r_s <= r_lim);
                r_num  <= r_s;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_ax   <= 2'd0;
            end
            ST_SQRT: begin
                r_rem  <= u_ge ? u_diff[RW-1:0] : u_sh[RW-1:0];
                r_root <= {r_root[RTW-2:0], u_ge};
                r_num  <= {r_num[PW-3:0], 2'b00};
                r_cnt  <= r_cnt + CW'(1);
            end
            ST_VMUL: r_prod <= mul_p;
            ST_VINIT: begin
                // quotient is bounded by the speed, so the top bits start as remainder
                r_rem <= r_prod[QW +: RW];
                r_num <= {r_prod[QW-1:0], (PW-QW)'(0)};
                r_q   <= '0;
                r_cnt <= '0;
                if (r_root == '0) begin
                    r_vel[r_ax] <= '0;
                    r_ax        <= r_ax + 2'd1;
                end
            end
            ST_VDIV: begin
                r_rem <= u_ge ? u_diff[RW-1:0] : u_sh[RW-1:0];
                r_q   <= {r_q[QW-2:0], u_ge};
                r_num <= {r_num[PW-2:0], 1'b0};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_vel[r_ax] <= d_cur[COORD_W] ? -q_ext : q_ext;
                    r_ax        <= r_ax + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_st != ST_IDLE);
    assign o_done      = (r_st == ST_DONE) && i_out_free;
    assign o_res.vel_x = r_vel[0];
    assign o_res.vel_y = r_vel[1];
    assign o_res.vel_z = r_vel[2];
    assign o_res.hit   = r_hit;
endmodule
`default_nettype wire

[dv/waypoint_velocity_follower_unit_tb.sv]
// Self-checking testbench of waypoint_velocity_follower_unit: streams waypoint writes and
// position samples, predicts each velocity command and checks every result beat.
// Depends on wvf_pkg, wvf_ifs and the RTL of the block.
`timescale 1ns / 1ps

import wvf_pkg::*;

class wvf_velocity_scoreboard;
    t_coord       way_x[256];
    t_coord       way_y[256];
    t_coord       way_z[256];
    bit           loaded[256];
    int unsigned  aim_idx;
    int unsigned  path_len;
    int unsigned  thr;
    int unsigned  speed;
    t_out_item    pending_cmds[$];
    int           errors;

    function new();
        aim_idx  = 0;
        path_len = 0;
        thr      = THR_RESET;
        speed    = SPD_RESET;
        errors   = 0;
        foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        case (idx)
            CFG_PATH_LENGTH:     path_len = val[LEN_W-1:0];
            CFG_REACH_THRESHOLD: thr      = val[THR_W-1:0];
            CFG_CRUISE_SPEED:    speed    = val[SPD_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] scale_axis(logic signed [32:0] d, logic [127:0] norm);
        logic [127:0] m;
        if (norm == 0) return '0;
        m = ((d < 0) ? 128'(-d) : 128'(d)) * 128'(speed) / norm;
        if (d < 0) m = -m;
        return m[31:0];
    endfunction

    function void note_beat(t_in_item it);
        int unsigned       len;
        logic signed [32:0] dx, dy, dz;
        logic [127:0]      s, lim, root, c;
        t_out_item         cmd;
        if (it.operation == OP_WRITE) begin
            way_x[it.waypoint_slot] = it.coord_x;
            way_y[it.waypoint_slot] = it.coord_y;
            way_z[it.waypoint_slot] = it.coord_z;
            loaded[it.waypoint_slot] = 1;
            return;
        end
        len = (path_len > 256) ? 256 : path_len;
        if (len == 0) return;
        if (aim_idx >= len) aim_idx = 0;
        dx = 33'(way_x[aim_idx]) - 33'(it.coord_x);
        dy = 33'(way_y[aim_idx]) - 33'(it.coord_y);
        dz = 33'(way_z[aim_idx]) - 33'(it.coord_z);
        s = 128'(66'(dx) * 66'(dx)) + 128'(66'(dy) * 66'(dy)) + 128'(66'(dz) * 66'(dz));
        lim = 128'(3) * 128'(thr) * 128'(thr);
        root = 0;
        for (int b = 40; b >= 0; b--) begin
            c = root | (128'(1) << b);
            if (c * c <= s) root = c;
        end
        cmd.vel_x       = scale_axis(dx, root);
        cmd.vel_y       = scale_axis(dy, root);
        cmd.vel_z       = scale_axis(dz, root);
        cmd.aimed_index = aim_idx[7:0];
        cmd.reached     = (s <= lim);
        pending_cmds = {pending_cmds, cmd};
        if (cmd.reached) aim_idx = (aim_idx + 1 >= len) ? 0 : aim_idx + 1;
    endfunction

    function void check_beat(t_out_item got);
        t_out_item exp_cmd;
        if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result beat %h", $realtime, got);
            errors++;
            return;
        end
        exp_cmd = pending_cmds.pop_front();
        if (got.vel_x !== exp_cmd.vel_x) begin
            $display("%0t: vel_x exp %h got %h", $realtime, exp_cmd.vel_x, got.vel_x);
            errors++;
        end
        if (got.vel_y !== exp_cmd.vel_y) begin
            $display("%0t: vel_y exp %h got %h", $realtime, exp_cmd.vel_y, got.vel_y);
            errors++;
        end
        if (got.vel_z !== exp_cmd.vel_z) begin
            $display("%0t: vel_z exp %h got %h", $realtime, exp_cmd.vel_z, got.vel_z);
            errors++;
        end
        if (got.aimed_index !== exp_cmd.aimed_index) begin
            $display("%0t: aimed_index exp %0d got %0d", $realtime, exp_cmd.aimed_index,
                     got.aimed_index);
            errors++;
        end
        if (got.reached !== exp_cmd.reached) begin
            $display("%0t: reached exp %0b got %0b", $realtime, exp_cmd.reached, got.reached);
            errors++;
        end
    endfunction
endclass

module waypoint_velocity_follower_unit_tb;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    wvf_in_if  in_if();
    wvf_out_if out_if();
    wvf_cfg_if cfg_if();

    wvf_velocity_scoreboard sb;
    bit burst;
    int idle_cycles;

    waypoint_velocity_follower_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .i_cfg  (cfg_if.sink),
        .o_out  (out_if.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // monitor, scoreboard updates and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_beat(in_if.data);
            if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
            if (out_if.valid && out_if.ready) sb.check_beat(out_if.data);
            if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result sink with random stalls
    initial begin
        int w;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            w = burst ? 0 : $urandom_range(0, 14);
            repeat (w) @(negedge i_clk);
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            @(negedge i_clk);
            out_if.ready = 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_beat(logic op, logic [7:0] slot, t_coord x, t_coord y, t_coord z);
        int w;
        w = burst ? 0 : $urandom_range(0, 14);
        repeat (w) @(negedge i_clk);
        @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.data.operation     = op;
        in_if.data.waypoint_slot = slot;
        in_if.data.coord_x       = x;
        in_if.data.coord_y       = y;
        in_if.data.coord_z       = z;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // wait for every pending command plus the busy tail of the block
    task automatic drain();
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reconfigure(int unsigned len, int unsigned thr, int unsigned spd);
        drain();
        write_reg(CFG_PATH_LENGTH, CFG_DW'(len));
        write_reg(CFG_REACH_THRESHOLD, CFG_DW'(thr));
        write_reg(CFG_CRUISE_SPEED, CFG_DW'(spd));
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic t_coord near(t_coord c, int unsigned thr);
        int h;
        h = thr / 2;
        return c + ($signed($urandom_range(0, 2 * h)) - h);
    endfunction

    // one random beat; samples only aim at waypoints already written
    task automatic random_beat();
        int unsigned len, tgt, s;
        t_coord x, y, z;
        len = (sb.path_len > 256) ? 256 : sb.path_len;
        tgt = (sb.aim_idx >= len) ? 0 : sb.aim_idx;
        if (len != 0 && !sb.loaded[tgt]) begin
            send_beat(OP_WRITE, tgt[7:0], rand_coord(), rand_coord(), rand_coord());
            return;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                s = (len != 0 && $urandom_range(0, 1)) ? $urandom_range(0, len - 1)
                                                        : $urandom_range(0, 255);
                send_beat(OP_WRITE, s[7:0], rand_coord(), rand_coord(), rand_coord());
            end
            2, 3, 4, 5: begin
                x = near(sb.way_x[tgt], sb.thr);
                y = near(sb.way_y[tgt], sb.thr);
                z = near(sb.way_z[tgt], sb.thr);
                send_beat(OP_SAMPLE, 8'($urandom), x, y, z);
            end
            6: send_beat(OP_SAMPLE, 8'($urandom), sb.way_x[tgt], sb.way_y[tgt],
                         sb.way_z[tgt]);
            default: send_beat(OP_SAMPLE, 8'($urandom), rand_coord(), rand_coord(),
                               rand_coord());
        endcase
    endtask

    initial begin
        int unsigned cfg_len[8] = '{4, 256, 1, 2, 37, 0, 256, 3};
        int unsigned cfg_thr[8] = '{0, 65535, 3277, 65535, 1000, 100, 40000, 12};
        int unsigned cfg_spd[8] = '{1048575, 0, 3277, 1048575, 65536, 5, 777777, 1};
        sb = new();
        burst = 1'b0;
        idle_cycles = 0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_PATH_LENGTH;
        cfg_if.data  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: path length zero gives nothing, then extremes and special cases
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh0);
        send_beat(OP_WRITE, 8'd0, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_beat(OP_WRITE, 8'd1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(OP_WRITE, 8'd2, 32'sh0, 32'sh0, 32'sh0);
        send_beat(OP_WRITE, 8'd3, 32'sh00010000, -32'sh00010000, 32'sh00008000);
        send_beat(OP_WRITE, 8'd255, 32'shffffffff, 32'sh1, 32'sh80000000);
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh0);
        drain();
        write_reg(CFG_PATH_LENGTH, CFG_DW'(4));
        send_beat(OP_SAMPLE, 8'hff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_beat(OP_SAMPLE, 8'd0, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_beat(OP_SAMPLE, 8'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(OP_SAMPLE, 8'd0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh0);
        send_beat(OP_SAMPLE, 8'd0, 32'sh00010000, -32'sh00010000, 32'sh00008010);
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh1);
        reconfigure(256, 0, 1048575);
        send_beat(OP_SAMPLE, 8'd0, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh0);
        send_beat(OP_SAMPLE, 8'd0, 32'sh0, 32'sh0, 32'sh0);
        // lowering the path length pulls the target back to slot 0
        reconfigure(1, 65535, 0);
        send_beat(OP_SAMPLE, 8'd0, 32'sh12345678, -32'sh1234, 32'sh0);

        for (int p = 0; p < 16; p++) begin
            if (p < 8)
                reconfigure(cfg_len[p], cfg_thr[p], cfg_spd[p]);
            else
                reconfigure($urandom_range(0, 256), $urandom_range(0, 65535),
                            $urandom_range(0, 1048575));
            burst = (p % 5 == 2);
            for (int n = 0; n < 95; n++) random_beat();
        end
        burst = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/wvf_pkg.sv
rtl/wvf_ifs.sv
rtl/wvf_waymem.sv
rtl/wvf_core.sv
rtl/waypoint_velocity_follower_unit.sv
dv/waypoint_velocity_follower_unit_tb.sv
